/* hw/rtl/two_stage_decimating_fir_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-stage decimating FIR
// Shared implication forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_STAGE_DECIMATING_FIR_TOP_DEFINES_SVH
`define TWO_STAGE_DECIMATING_FIR_TOP_DEFINES_SVH

// same-cycle implication
`define FIR2_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FIR2_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/fir2_pkg.sv */
// ----------------------------------------------------------------------------
// fir2_pkg
// Types and constants shared by the two-stage decimating FIR.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fir2_pkg;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_COEF   = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DEC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DEC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TAPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_TAPS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP       = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_DEC     = 16;
    localparam int ACC_W       = 88;
    localparam int MID_W       = 48;
    localparam int S1_SHIFT    = 13;
    localparam int S2_SHIFT    = 45;
    localparam int HALF_W      = 24;

    localparam logic signed [ACC_W-1:0] S1_BIAS = ACC_W'((64'd1 << S1_SHIFT) - 64'd1);
    localparam logic signed [ACC_W-1:0] S2_BIAS = ACC_W'((64'd1 << S2_SHIFT) - 64'd1);
    localparam logic signed [ACC_W-1:0] MID_HI  = ACC_W'(64'sh0000_7FFF_FFFF_FFFF);
    localparam logic signed [ACC_W-1:0] MID_LO  = -MID_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_HI  = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] OUT_LO  = -OUT_HI - ACC_W'(1);

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] sample;
        logic               coef_stage;
        logic [6:0]         coef_index;
        logic signed [31:0] coef_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] filtered_sample;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic [4:0] first_decimation;
        logic [4:0] second_decimation;
        logic [7:0] first_taps;
        logic [7:0] second_taps;
        logic [3:0] skip_count;
    } t_cfg;

    typedef enum logic [1:0] {
        K_SAMPLE,
        K_COEF,
        K_START
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               coef_stage;
        logic [6:0]         coef_index;
        logic signed [31:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FIN1,
        S_FIN2
    } t_state;

endpackage

/* hw/rtl/fir2_ram.sv */
// ----------------------------------------------------------------------------
// fir2_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/fir2_fifo.sv */
// ----------------------------------------------------------------------------
// fir2_fifo
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir2_fifo #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [NW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

/* hw/rtl/fir2_front.sv */
// ----------------------------------------------------------------------------
// fir2_front
// Accepts input beats, drops skipped and invalid items, queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir2_front #(
    parameter int MAX_TAPS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fir2_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fir2_pkg::t_in i_in_data,
    input  logic          i_full,
    output logic          o_push,
    output fir2_pkg::t_cmd o_cmd
);
    import fir2_pkg::*;

    logic [3:0] r_skipped, n_skipped;
    logic       accept;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        n_skipped        = r_skipped;
        o_push           = 1'b0;
        o_cmd.kind       = K_SAMPLE;
        o_cmd.coef_stage = i_in_data.coef_stage;
        o_cmd.coef_index = i_in_data.coef_index;
        o_cmd.value      = i_in_data.sample;
        if (accept) begin
            case (i_in_data.mode)
                MODE_SAMPLE: begin
                    if (r_skipped < i_cfg.skip_count) begin
                        n_skipped = r_skipped + 4'd1;
                    end else begin
                        o_push = 1'b1;
                    end
                end
                MODE_COEF: begin
                    o_cmd.kind  = K_COEF;
                    o_cmd.value = i_in_data.coef_value;
                    o_push      = (32'(i_in_data.coef_index) < MAX_TAPS);
                end
                MODE_START: begin
                    o_cmd.kind = K_START;
                    n_skipped  = '0;
                    o_push     = 1'b1;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skipped <= '0;
        end else begin
            r_skipped <= n_skipped;
        end
    end

endmodule

/* hw/rtl/fir2_back.sv */
// ----------------------------------------------------------------------------
// fir2_back
// Executes queued commands: coefficient writes, series starts and the two
// filter stages on one shared multiply-accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_stage_decimating_fir_top_defines.svh"

module fir2_back #(
    parameter int MAX_TAPS = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fir2_pkg::t_cfg i_cfg,
    input  logic           i_empty,
    input  fir2_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fir2_pkg::t_out o_out_data
);
    import fir2_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);

    function automatic logic [CW-1:0] f_taps(input logic [7:0] raw);
        logic [CW-1:0] r;
        if (raw == 8'd0) begin
            r = CW'(1);
        end else if (32'(raw) > MAX_TAPS) begin
            r = CW'(MAX_TAPS);
        end else begin
            r = CW'(raw);
        end
        return r;
    endfunction

    function automatic logic [4:0] f_dec(input logic [4:0] raw);
        logic [4:0] r;
        if (raw == 5'd0) begin
            r = 5'd1;
        end else if (32'(raw) > MAX_DEC) begin
            r = 5'(MAX_DEC);
        end else begin
            r = raw;
        end
        return r;
    endfunction

    // oldest sample of the window, newest sits at wp
    function automatic logic [AW-1:0] f_start(input logic [AW-1:0] wp,
                                              input logic [CW-1:0] taps);
        logic [CW:0] w, d, r;
        w = (CW+1)'(wp);
        d = (CW+1)'(taps) - (CW+1)'(1);
        if (w >= d) begin
            r = w - d;
        end else begin
            r = w + (CW+1)'(MAX_TAPS) - d;
        end
        return AW'(r);
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == AW'(MAX_TAPS - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [3:0] f_phase(input logic [3:0] ph, input logic [4:0] dec);
        logic [4:0] p;
        p = {1'b0, ph} + 5'd1;
        return (p >= dec) ? 4'd0 : 4'(p);
    endfunction

    t_state r_state, n_state;
    logic [AW-1:0] r_wp1, n_wp1, r_wp2, n_wp2, r_addr, n_addr, r_tap, n_tap;
    logic [CW-1:0] r_fill1, n_fill1, r_fill2, n_fill2;
    logic [3:0]    r_ph1, n_ph1, r_ph2, n_ph2;
    logic          r_stage, n_stage, r_half, n_half;
    logic          r_p1_vld, n_p1_vld, r_p1_half, n_p1_half;
    logic          r_p2_vld, n_p2_vld, r_p2_half, n_p2_half;
    logic signed [64:0]      r_prod, n_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic          r_out_vld, n_out_vld;
    t_out          r_out, n_out;

    logic [CW-1:0] t1, t2, taps_cur, nf;
    logic [4:0]    d1, d2;
    logic          h1_we, h2_we, c1_we, c2_we, last;
    logic [31:0]   h1_rd, c1_rd, c2_rd;
    logic [MID_W-1:0] h2_rd, mid;
    logic signed [32:0]      a_op;
    logic signed [31:0]      b_op;
    logic signed [ACC_W-1:0] addend, q1, q2, sat2;
    logic          clip2;

    assign t1 = f_taps(i_cfg.first_taps);
    assign t2 = f_taps(i_cfg.second_taps);
    assign d1 = f_dec(i_cfg.first_decimation);
    assign d2 = f_dec(i_cfg.second_decimation);
    assign taps_cur = r_stage ? t2 : t1;
    assign last = (CW'(r_tap) == taps_cur - CW'(1)) && (!r_stage || r_half);

    fir2_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_hist1 (
        .i_clk(i_clk), .i_we(h1_we), .i_waddr(r_wp1), .i_wdata(i_cmd.value),
        .i_raddr(r_addr), .o_rdata(h1_rd)
    );
    fir2_ram #(.WIDTH(MID_W), .DEPTH(MAX_TAPS)) u_hist2 (
        .i_clk(i_clk), .i_we(h2_we), .i_waddr(r_wp2), .i_wdata(mid),
        .i_raddr(r_addr), .o_rdata(h2_rd)
    );
    fir2_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_coef1 (
        .i_clk(i_clk), .i_we(c1_we), .i_waddr(AW'(i_cmd.coef_index)),
        .i_wdata(i_cmd.value), .i_raddr(r_tap), .o_rdata(c1_rd)
    );
    fir2_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_coef2 (
        .i_clk(i_clk), .i_we(c2_we), .i_waddr(AW'(i_cmd.coef_index)),
        .i_wdata(i_cmd.value), .i_raddr(r_tap), .o_rdata(c2_rd)
    );

    // stage two splits the 48-bit history into low unsigned and high signed halves
    always_comb begin
        if (!r_stage) begin
            a_op = 33'($signed(h1_rd));
            b_op = $signed(c1_rd);
        end else begin
            b_op = $signed(c2_rd);
            if (r_p1_half) begin
                a_op = 33'($signed(h2_rd[MID_W-1:HALF_W]));
            end else begin
                a_op = $signed({9'd0, h2_rd[HALF_W-1:0]});
            end
        end
        addend = r_p2_half ? (ACC_W'(r_prod) <<< HALF_W) : ACC_W'(r_prod);
    end

    // truncate toward zero, then saturate
    always_comb begin
        q1 = (r_acc[ACC_W-1] ? r_acc + S1_BIAS : r_acc) >>> S1_SHIFT;
        if (q1 > MID_HI) begin
            mid = MID_HI[MID_W-1:0];
        end else if (q1 < MID_LO) begin
            mid = MID_LO[MID_W-1:0];
        end else begin
            mid = q1[MID_W-1:0];
        end
        q2 = (r_acc[ACC_W-1] ? r_acc + S2_BIAS : r_acc) >>> S2_SHIFT;
        clip2 = 1'b1;
        if (q2 > OUT_HI) begin
            sat2 = OUT_HI;
        end else if (q2 < OUT_LO) begin
            sat2 = OUT_LO;
        end else begin
            sat2  = q2;
            clip2 = 1'b0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_wp1     = r_wp1;
        n_wp2     = r_wp2;
        n_addr    = r_addr;
        n_tap     = r_tap;
        n_fill1   = r_fill1;
        n_fill2   = r_fill2;
        n_ph1     = r_ph1;
        n_ph2     = r_ph2;
        n_stage   = r_stage;
        n_half    = r_half;
        n_p1_vld  = 1'b0;
        n_p1_half = r_half;
        n_p2_vld  = r_p1_vld;
        n_p2_half = r_p1_half;
        n_prod    = a_op * b_op;
        n_acc     = r_p2_vld ? r_acc + addend : r_acc;
        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;
        o_pop     = 1'b0;
        h1_we     = 1'b0;
        h2_we     = 1'b0;
        c1_we     = 1'b0;
        c2_we     = 1'b0;
        nf        = r_fill1;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        K_COEF: begin
                            c1_we = !i_cmd.coef_stage;
                            c2_we = i_cmd.coef_stage;
                        end
                        K_START: begin
                            n_fill1 = '0;
                            n_fill2 = '0;
                            n_ph1   = '0;
                            n_ph2   = '0;
                        end
                        K_SAMPLE: begin
                            h1_we   = 1'b1;
                            n_wp1   = f_inc(r_wp1);
                            nf      = (r_fill1 == CW'(MAX_TAPS)) ? r_fill1 : r_fill1 + CW'(1);
                            n_fill1 = nf;
                            if (nf >= t1) begin
                                n_ph1 = f_phase(r_ph1, d1);
                                if (r_ph1 == 4'd0) begin
                                    n_stage = 1'b0;
                                    n_half  = 1'b0;
                                    n_addr  = f_start(r_wp1, t1);
                                    n_tap   = '0;
                                    n_acc   = '0;
                                    n_state = S_RUN;
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_RUN: begin
                n_p1_vld = 1'b1;
                if (r_stage && !r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    n_addr = f_inc(r_addr);
                    n_tap  = r_tap + AW'(1);
                    if (last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    n_state = r_stage ? S_FIN2 : S_FIN1;
                end
            end
            S_FIN1: begin
                h2_we   = 1'b1;
                n_wp2   = f_inc(r_wp2);
                nf      = (r_fill2 == CW'(MAX_TAPS)) ? r_fill2 : r_fill2 + CW'(1);
                n_fill2 = nf;
                n_state = S_IDLE;
                if (nf >= t2) begin
                    n_ph2 = f_phase(r_ph2, d2);
                    if (r_ph2 == 4'd0) begin
                        n_stage = 1'b1;
                        n_half  = 1'b0;
                        n_addr  = f_start(r_wp2, t2);
                        n_tap   = '0;
                        n_acc   = '0;
                        n_state = S_RUN;
                    end
                end
            end
            S_FIN2: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld             = 1'b1;
                    n_out.filtered_sample = sat2[31:0];
                    n_out.saturated       = clip2;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp1     <= '0;
            r_wp2     <= '0;
            r_fill1   <= '0;
            r_fill2   <= '0;
            r_ph1     <= '0;
            r_ph2     <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp1     <= n_wp1;
            r_wp2     <= n_wp2;
            r_fill1   <= n_fill1;
            r_fill2   <= n_fill2;
            r_ph1     <= n_ph1;
            r_ph2     <= n_ph2;
            r_p1_vld  <= n_p1_vld;
            r_p2_vld  <= n_p2_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_tap     <= n_tap;
        r_stage   <= n_stage;
        r_half    <= n_half;
        r_p1_half <= n_p1_half;
        r_p2_half <= n_p2_half;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `FIR2_ASSERT_IMP(a_pop_nonempty, o_pop, !i_empty, "pop from empty queue")
    `FIR2_ASSERT_IMP(a_fin_drained, (r_state == S_FIN1) || (r_state == S_FIN2), !r_p1_vld && !r_p2_vld, "finish before MAC drained")
    `FIR2_ASSERT_IMP(a_fill_bound, 1'b1, (r_fill1 <= CW'(MAX_TAPS)) && (r_fill2 <= CW'(MAX_TAPS)), "fill count overrun")
    `FIR2_ASSERT_NXT(a_run_issues, r_state == S_RUN, r_p1_vld, "run cycle issued no tap")

endmodule

/* hw/rtl/two_stage_decimating_fir_top.sv */
// The back end pops no queued item while a stage-one or stage-two window is being
// computed, and the front keeps queueing until the queue is full; windows are paced
// by the one shared multiply-accumulate (stage two uses it twice per tap).
// Reset: synchronous active-low; clears control, fills, phases and skip count.
// History and coefficient RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// two_stage_decimating_fir_top
// Two cascaded decimating FIR stages with a front classifier, command
// queue and a shared-MAC back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_stage_decimating_fir_top #(
    parameter int MAX_TAPS = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fir2_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fir2_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fir2_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fir2_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fir2_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd, pop_cmd;
    logic push, pop, q_empty, q_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_decimation  <= 5'd1;
            r_cfg.second_decimation <= 5'd1;
            r_cfg.first_taps        <= 8'd1;
            r_cfg.second_taps       <= 8'd1;
            r_cfg.skip_count        <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FIRST_DEC:   r_cfg.first_decimation  <= i_cfg_data[4:0];
                CFG_SECOND_DEC:  r_cfg.second_decimation <= i_cfg_data[4:0];
                CFG_FIRST_TAPS:  r_cfg.first_taps        <= i_cfg_data;
                CFG_SECOND_TAPS: r_cfg.second_taps       <= i_cfg_data;
                CFG_SKIP:        r_cfg.skip_count        <= i_cfg_data[3:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    fir2_front #(.MAX_TAPS(MAX_TAPS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    fir2_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .i_pop   (pop),
        .o_rdata (pop_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fir2_back #(.MAX_TAPS(MAX_TAPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (q_empty),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
